// ===== hw/rtl/bhc_pkg.sv =====
// Shared constants and types for the bitstream header classifier.
package bhc_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int PHASE_W    = 2;
    localparam int WORDS_W    = 27;
    localparam int COUNT1_W   = 11;
    localparam int FULL_LEN_W = 29;
    localparam int MODE_W     = 2;

    localparam logic [WORD_W-1:0] SYNC_WORD = 32'hAA99_5566;

    localparam logic [2:0] HDR_TYPE1    = 3'd1;
    localparam logic [2:0] HDR_TYPE2    = 3'd2;
    localparam logic [1:0] OP_WRITE     = 2'd2;
    localparam logic [4:0] REG_DATA_IN  = 5'd2;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PARTIAL = 2'd2;

    typedef struct packed {
        logic               hit;
        logic [WORDS_W-1:0] words;
        logic               want_type2;
    } t_word_result;

endpackage

// ===== hw/rtl/bhc_if.sv =====
// Handshake channels of the bitstream header classifier.
interface bhc_in_if import bhc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface bhc_out_if import bhc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [WORDS_W-1:0] payload_words;

    modport source (output valid, output mode, output payload_words, input ready);
    modport sink   (input valid, input mode, input payload_words, output ready);
endinterface

interface bhc_cfg_if import bhc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FULL_LEN_W-1:0] full_length_bytes;

    modport source (output valid, output full_length_bytes, input ready);
    modport sink   (input valid, input full_length_bytes, output ready);
endinterface

// ===== hw/rtl/bhc_word_check.sv =====
// Packet header decode of one assembled word.
module bhc_word_check import bhc_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_want_type2,
    output t_word_result      o_result
);

    logic [2:0]          w_hdr;
    logic [1:0]          w_op;
    logic [4:0]          w_addr;
    logic [COUNT1_W-1:0] w_count1;
    logic                w_type1_hit;

    assign w_hdr       = i_word[31:29];
    assign w_op        = i_word[28:27];
    assign w_addr      = i_word[17:13];
    assign w_count1    = i_word[COUNT1_W-1:0];
    assign w_type1_hit = (w_hdr == HDR_TYPE1) && (w_op == OP_WRITE) && (w_addr == REG_DATA_IN);

    always_comb begin
        o_result = '0;
        if (i_want_type2 && (w_hdr == HDR_TYPE2)) begin
            o_result.hit   = 1'b1;
            o_result.words = i_word[WORDS_W-1:0];
        end else if (w_type1_hit) begin
            if (w_count1 != '0) begin
                o_result.hit   = 1'b1;
                o_result.words = {{(WORDS_W-COUNT1_W){1'b0}}, w_count1};
            end else begin
                o_result.want_type2 = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/bitstream_header_classifier.sv =====
// An accepted byte sits in the input register, its result in the output register.
// Throughput: one byte per cycle; a waiting result does not stop intake while
// the input register is free, and a full pipeline stalls only on the output side.
// Synchronous active-low reset clears the parser state, the pipeline valids and
// the full length register (to 0).
module bitstream_header_classifier import bhc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bhc_cfg_if.sink    i_cfg,
    bhc_in_if.sink     i_in,
    bhc_out_if.source  o_out
);

    logic [FULL_LEN_W-1:0] r_full_len;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic [WORD_W-1:0]  r_win,     n_win;
    logic               r_sync,    n_sync;
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic               r_want2,   n_want2;
    logic               r_decided, n_decided;

    logic               r_out_valid;
    logic [MODE_W-1:0]  r_mode,  n_mode;
    logic [WORDS_W-1:0] r_words, n_words;
    logic               n_hit;

    logic               w_adv;
    logic               w_fire;
    logic [WORD_W-1:0]  w_win_shift;
    logic [PHASE_W-1:0] w_phase_inc;
    t_word_result       w_chk;

    assign w_adv    = !r_out_valid || o_out.ready;
    assign w_fire   = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign w_win_shift = {r_win[WORD_W-BYTE_W-1:0], r_byte};
    assign w_phase_inc = r_phase + PHASE_W'(1);

    bhc_word_check u_word_check (
        .i_word       (w_win_shift),
        .i_want_type2 (r_want2),
        .o_result     (w_chk)
    );

    always_comb begin
        n_win     = r_win;
        n_sync    = r_sync;
        n_phase   = r_phase;
        n_want2   = r_want2;
        n_decided = r_decided;
        n_hit     = 1'b0;
        n_mode    = MODE_UNKNOWN;
        n_words   = '0;
        if (!r_decided) begin
            n_win = w_win_shift;
            if (!r_sync) begin
                if (w_win_shift == SYNC_WORD) begin
                    n_sync  = 1'b1;
                    n_phase = '0;
                end
            end else begin
                n_phase = w_phase_inc;
                if (w_phase_inc == '0) begin
                    n_want2 = w_chk.want_type2;
                    if (w_chk.hit) begin
                        n_hit     = 1'b1;
                        n_decided = 1'b1;
                        n_words   = w_chk.words;
                        n_mode    = ({w_chk.words, 2'b00} == r_full_len) ? MODE_FULL
                                                                          : MODE_PARTIAL;
                    end
                end
            end
        end
        if (r_last) begin
            if (!n_hit && !r_decided) begin
                n_hit   = 1'b1;
                n_mode  = MODE_UNKNOWN;
                n_words = '0;
            end
            n_win     = '0;
            n_sync    = 1'b0;
            n_phase   = '0;
            n_want2   = 1'b0;
            n_decided = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_len <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_full_len <= i_cfg.full_length_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_sync    <= 1'b0;
            r_phase   <= '0;
            r_want2   <= 1'b0;
            r_decided <= 1'b0;
        end else if (w_fire) begin
            r_win     <= n_win;
            r_sync    <= n_sync;
            r_phase   <= n_phase;
            r_want2   <= n_want2;
            r_decided <= n_decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_hit) begin
            r_mode  <= n_mode;
            r_words <= n_words;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.mode          = r_mode;
    assign o_out.payload_words = r_words;

    // parser state consistency
    a_decided_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decided |-> r_sync)
        else $error("decided without sync");

    a_phase_needs_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != '0) |-> r_sync)
        else $error("word phase advanced before sync");

    a_want2_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_want2 |-> (r_sync && !r_decided))
        else $error("type-2 expectation outside a live stream");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_mode == MODE_UNKNOWN)) |-> (r_words == '0))
        else $error("unknown result with nonzero word count");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_mode == MODE_UNKNOWN) || (r_mode == MODE_FULL)
                         || (r_mode == MODE_PARTIAL)))
        else $error("illegal result mode");

endmodule
